// ----- src/lfe_pkg.sv -----
// Shared constants and types for the linear fade envelope unit.
package lfe_pkg;

   // Field and register widths
   localparam int SAMPLE_W       = 16;
   localparam int MS_W           = 10;
   localparam int POS_W          = 24;
   localparam int SAMPLES_PER_MS = 200;

   // Ramp length in samples: widest value is the largest ms setting times the rate
   localparam int RAMP_MAX = ((1 << MS_W) - 1) * SAMPLES_PER_MS;
   localparam int RAMP_W   = $clog2(RAMP_MAX + 1);

   // Magnitude times ramp position, and the serial divider step count
   localparam int PROD_W = SAMPLE_W + RAMP_W;
   localparam int CNT_W  = $clog2(SAMPLE_W);

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RISE_MS       = 2'd0,
      CSR_FALL_MS       = 2'd1,
      CSR_BUFFER_LENGTH = 2'd2
   } csr_index_type;

endpackage

// ----- src/linear_fade_envelope_unit.sv -----
// Linear fade-in / fade-out envelope over buffers of signed 16-bit samples.
//
// Each request carries one sample; the unit tracks the sample's position in the
// current buffer and scales it by n/R on the rising ramp and by j/F on the
// falling ramp (j counted back from the buffer end), truncating toward zero.
// Both ramps share one 16 x 18 multiplier and one restoring divider that
// produces one quotient bit per cycle. Each active ramp runs operand load,
// multiply, 16 divide steps and sign fix-up in turn. The result sits in an
// output register, so a new sample is taken while the previous result waits.
// rsp_tlast marks the last sample of a buffer, after which the position
// returns to zero.
// Configuration is written through the csr channel, always ready.
module linear_fade_envelope_unit
   import lfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // [15:0] sample_in
   // Response stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]  rsp_tdata,   // [15:0] sample_out
   output logic                 rsp_tlast,   // buffer_end
   // Configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [POS_W-1:0]     csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_DIV,
      ST_SIGN,
      ST_FINISH
   } state_type;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_W - 1);

   state_type                  state_ff;
   logic [RAMP_W-1:0]          rise_len_ff;
   logic [RAMP_W-1:0]          fall_len_ff;
   logic [POS_W-1:0]           buf_len_ff;
   logic [POS_W-1:0]           position_ff;
   logic signed [SAMPLE_W-1:0] val_ff;
   logic                       rise_pend_ff;
   logic                       fall_pend_ff;
   logic [RAMP_W-1:0]          n_ff;
   logic [RAMP_W-1:0]          j_ff;
   logic                       last_ff;
   logic [RAMP_W-1:0]          num_ff;
   logic [RAMP_W-1:0]          den_ff;
   logic [RAMP_W-1:0]          rem_ff;
   logic [SAMPLE_W-1:0]        low_ff;
   logic [SAMPLE_W-1:0]        quo_ff;
   logic                       neg_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_data_ff;
   logic                       rsp_last_ff;

   logic [POS_W-1:0]           len_in;
   logic [POS_W-1:0]           last_in;
   logic                       at_end;
   logic [POS_W-1:0]           j_in;
   logic [POS_W-1:0]           position_in;
   logic                       rise_hit;
   logic                       fall_hit;
   logic [SAMPLE_W-1:0]        mag_in;
   logic [PROD_W-1:0]          product_in;
   logic [RAMP_W:0]            trial;
   logic                       qbit_in;
   logic [RAMP_W-1:0]          rem_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Position within the buffer: end test, distance to end, ramp hits
   always_comb begin
      len_in      = (buf_len_ff == '0) ? POS_W'(1) : buf_len_ff;
      last_in     = len_in - POS_W'(1);
      at_end      = (position_ff >= last_in);
      j_in        = at_end ? '0 : (last_in - position_ff);
      position_in = at_end ? '0 : (position_ff + POS_W'(1));
      rise_hit    = (rise_len_ff != '0) && (position_ff < POS_W'(rise_len_ff));
      fall_hit    = (fall_len_ff != '0) && (j_in < POS_W'(fall_len_ff));
   end

   // Shared multiplier on the sample magnitude
   always_comb begin
      mag_in     = val_ff[SAMPLE_W-1] ? SAMPLE_W'(-val_ff) : SAMPLE_W'(val_ff);
      product_in = PROD_W'(mag_in) * PROD_W'(num_ff);
   end

   // Shared restoring divider step: one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, low_ff[SAMPLE_W-1]};
      qbit_in = (trial >= {1'b0, den_ff});
      rem_in  = qbit_in ? RAMP_W'(trial - {1'b0, den_ff}) : trial[RAMP_W-1:0];
   end

   // Sequencer, configuration registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rise_len_ff  <= '0;
         fall_len_ff  <= '0;
         buf_len_ff   <= POS_W'(1);
         position_ff  <= '0;
         rise_pend_ff <= 1'b0;
         fall_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Take configuration writes, storing ramp lengths in samples
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_RISE_MS: begin
                  rise_len_ff <= RAMP_W'(csr_data[MS_W-1:0] * SAMPLES_PER_MS);
               end
               CSR_FALL_MS: begin
                  fall_len_ff <= RAMP_W'(csr_data[MS_W-1:0] * SAMPLES_PER_MS);
               end
               CSR_BUFFER_LENGTH: begin
                  buf_len_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end

         // Drop the response once taken, unless the finish step reloads it
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  val_ff       <= $signed(req_tdata);
                  rise_pend_ff <= rise_hit;
                  fall_pend_ff <= fall_hit;
                  n_ff         <= position_ff[RAMP_W-1:0];
                  j_ff         <= j_in[RAMP_W-1:0];
                  last_ff      <= at_end;
                  position_ff  <= position_in;
                  state_ff     <= ST_START;
               end
            end
            ST_START: begin
               // Rise ramp first, then fall ramp on its result
               priority if (rise_pend_ff) begin
                  num_ff       <= n_ff;
                  den_ff       <= rise_len_ff;
                  rise_pend_ff <= 1'b0;
                  state_ff     <= ST_MUL;
               end else if (fall_pend_ff) begin
                  num_ff       <= j_ff;
                  den_ff       <= fall_len_ff;
                  fall_pend_ff <= 1'b0;
                  state_ff     <= ST_MUL;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_MUL: begin
               rem_ff   <= product_in[PROD_W-1:SAMPLE_W];
               low_ff   <= product_in[SAMPLE_W-1:0];
               neg_ff   <= val_ff[SAMPLE_W-1];
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               low_ff <= {low_ff[SAMPLE_W-2:0], 1'b0};
               quo_ff <= {quo_ff[SAMPLE_W-2:0], qbit_in};
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_LAST) begin
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               val_ff   <= neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
               state_ff <= ST_START;
            end
            ST_FINISH: begin
               // Hold until the response register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= val_ff;
                  rsp_last_ff  <= last_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   // Divider remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");

   // Ramp gain never exceeds one, so the quotient magnitude fits a sample
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> (quo_ff <= {1'b1, {(SAMPLE_W-1){1'b0}}}))
      else $error("ramp quotient exceeds sample range");

   // Position returns to zero after the last sample of a buffer
   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && at_end) |=> (position_ff == '0))
      else $error("position not cleared at buffer end");

   // A new response only appears on leaving the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish step");
`endif

endmodule
